### sv/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types and constants for the light signal sequencer: request codes,
// register indexes, reset values and the one-hot state encodings.
// ----------------------------------------------------------------------------
package lss_pkg;

	// light level range
	localparam int unsigned LEVEL_W = 6;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 6'd63;
	localparam logic [LEVEL_W-1:0] LEVEL_MIN = 6'd0;

	// signal request codes; codes above task complete start no machine
	localparam logic [2:0] REQ_NONE = 3'd0;
	localparam logic [2:0] REQ_ACK  = 3'd1;
	localparam logic [2:0] REQ_NACK = 3'd2;
	localparam logic [2:0] REQ_ATTN = 3'd3;
	localparam logic [2:0] REQ_TASK = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CFG_ON_TIME  = 2'd0;
	localparam logic [1:0] CFG_OFF_TIME = 2'd1;
	localparam logic [1:0] CFG_FLASHES  = 2'd2;

	// configuration reset values
	localparam logic [31:0] ON_TIME_RST  = 32'd200000;
	localparam logic [31:0] OFF_TIME_RST = 32'd200000;
	localparam logic [7:0]  FLASHES_RST  = 8'd10;

	// attention machine
	typedef enum logic [2:0] {
		ATT_REST = 3'b001,
		ATT_ON   = 3'b010,
		ATT_OFF  = 3'b100
	} att_state_t;

	// nack machine: on, off, on
	typedef enum logic [3:0] {
		NACK_IDLE = 4'b0001,
		NACK_ON1  = 4'b0010,
		NACK_OFF  = 4'b0100,
		NACK_ON2  = 4'b1000
	} nack_state_t;

	// ack machine: one on pulse
	typedef enum logic [1:0] {
		ACK_IDLE = 2'b01,
		ACK_ON   = 2'b10
	} ack_state_t;

	// task-complete ramp machine
	typedef enum logic [2:0] {
		RAMP_IDLE = 3'b001,
		RAMP_RISE = 3'b010,
		RAMP_FALL = 3'b100
	} ramp_state_t;

endpackage

### sv/light_signal_sequencer.sv
// ----------------------------------------------------------------------------
// light_signal_sequencer
// Light level control with manual buttons and four signal patterns, three timed.
// ----------------------------------------------------------------------------
// Each input item is one control tick and gives exactly one result item with
// the light level and a flag that a signal pattern is running. The block takes
// one item per clock cycle unless the result side stalls. An item is held in
// an input register while it waits for the result register, and all
// pattern logic (two 32-bit elapsed-time compares and the level chain) sits
// between that register and the result register, and the state is updated in
// the same cycle the result is written. Timing comes only from the now_us
// field of each item: phases end when the wrapped difference to the shared
// phase start exceeds the on or off time. Registers are written through the
// cfg channel, which is always ready; writes are meant for idle periods only.
// ----------------------------------------------------------------------------
module light_signal_sequencer
	import lss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	// [31:0] now_us, [34:32] request, [35] manual_enable,
	// [36] joystick_present, [37] brighter, [38] dimmer, [39] reset_button
	input  logic [39:0] s_tdata,
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	// [5:0] light_level, [6] pattern_active, [7] zero
	output logic [7:0]  m_tdata,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	// configuration registers
	logic [31:0] on_time_q;
	logic [31:0] off_time_q;
	logic [7:0]  flashes_q;

	// input stage
	logic        valid_s1;
	logic [31:0] now_s1;
	logic [2:0]  req_s1;
	logic        man_s1;
	logic        joy_s1;
	logic        up_s1;
	logic        down_s1;
	logic        rstb_s1;

	// block state
	logic [LEVEL_W-1:0] level_q;
	att_state_t         att_q;
	nack_state_t        nack_q;
	ack_state_t         ack_q;
	ramp_state_t        ramp_q;
	logic [7:0]         fc_q;
	logic [31:0]        start_q;

	// next state
	logic [LEVEL_W-1:0] lvl_d;
	att_state_t         att_d;
	nack_state_t        nack_d;
	ack_state_t         ack_d;
	ramp_state_t        ramp_d;
	logic [7:0]         fc_d;
	logic [7:0]         fc_inc;
	logic [31:0]        start_d;
	logic               fresh;
	logic               active_d;

	// timing
	logic [31:0] elapsed;
	logic        on_exp;
	logic        off_exp;

	// output register
	logic        out_valid_q;
	logic [5:0]  out_level_q;
	logic        out_active_q;

	logic advance;

	// handshake: the stage item moves on when the result register is free
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_time_q  <= ON_TIME_RST;
			off_time_q <= OFF_TIME_RST;
			flashes_q  <= FLASHES_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ON_TIME:  on_time_q  <= cfg_data;
				CFG_OFF_TIME: off_time_q <= cfg_data;
				CFG_FLASHES:  flashes_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			now_s1  <= s_tdata[31:0];
			req_s1  <= s_tdata[34:32];
			man_s1  <= s_tdata[35];
			joy_s1  <= s_tdata[36];
			up_s1   <= s_tdata[37];
			down_s1 <= s_tdata[38];
			rstb_s1 <= s_tdata[39];
		end
	end

	// elapsed time against the shared phase start, wraps mod 2^32
	assign elapsed = now_s1 - start_q;
	assign on_exp  = elapsed > on_time_q;
	assign off_exp = elapsed > off_time_q;

	// one tick: buttons, request, then the four machines in fixed order;
	// once the timer restarts in this tick no later phase can expire
	always_comb begin
		lvl_d   = level_q;
		att_d   = att_q;
		nack_d  = nack_q;
		ack_d   = ack_q;
		ramp_d  = ramp_q;
		fc_d    = fc_q;
		fc_inc  = fc_q + 8'd1;
		start_d = start_q;
		fresh   = 1'b0;

		// manual buttons
		if (man_s1) begin
			if (up_s1) begin
				if (lvl_d != LEVEL_MAX) lvl_d = lvl_d + 6'd1;
			end else if (down_s1) begin
				if (lvl_d != LEVEL_MIN) lvl_d = lvl_d - 6'd1;
			end
		end
		if (joy_s1 && rstb_s1) lvl_d = LEVEL_MIN;

		// any request clears the level and restarts the timer and its machine, if any
		if (req_s1 != REQ_NONE) begin
			case (req_s1)
				REQ_ACK:  ack_d  = ACK_ON;
				REQ_NACK: nack_d = NACK_ON1;
				REQ_ATTN: begin
					att_d = ATT_ON;
					fc_d  = 8'd0;
				end
				REQ_TASK: ramp_d = RAMP_RISE;
				default: ;
			endcase
			lvl_d   = LEVEL_MIN;
			start_d = now_s1;
			fresh   = 1'b1;
		end
		fc_inc = fc_d + 8'd1;

		// attention
		case (att_d)
			ATT_ON: begin
				lvl_d = LEVEL_MAX;
				if (!fresh && on_exp) begin
					att_d   = ATT_OFF;
					start_d = now_s1;
					fresh   = 1'b1;
				end
			end
			ATT_OFF: begin
				lvl_d = LEVEL_MIN;
				if (!fresh && off_exp) begin
					start_d = now_s1;
					fresh   = 1'b1;
					if (fc_inc >= flashes_q) begin
						att_d = ATT_REST;
						fc_d  = 8'd0;
					end else begin
						att_d = ATT_ON;
						fc_d  = fc_inc;
					end
				end
			end
			default: ;
		endcase

		// nack
		case (nack_d)
			NACK_ON1: begin
				lvl_d = LEVEL_MAX;
				if (!fresh && on_exp) begin
					nack_d  = NACK_OFF;
					start_d = now_s1;
					fresh   = 1'b1;
				end
			end
			NACK_OFF: begin
				lvl_d = LEVEL_MIN;
				if (!fresh && off_exp) begin
					nack_d  = NACK_ON2;
					start_d = now_s1;
					fresh   = 1'b1;
				end
			end
			NACK_ON2: begin
				lvl_d = LEVEL_MAX;
				if (!fresh && on_exp) begin
					nack_d  = NACK_IDLE;
					start_d = now_s1;
					fresh   = 1'b1;
					lvl_d   = LEVEL_MIN;
				end
			end
			default: ;
		endcase

		// ack
		case (ack_d)
			ACK_ON: begin
				lvl_d = LEVEL_MAX;
				if (!fresh && on_exp) begin
					ack_d   = ACK_IDLE;
					start_d = now_s1;
					fresh   = 1'b1;
					lvl_d   = LEVEL_MIN;
				end
			end
			default: ;
		endcase

		// task-complete ramp
		case (ramp_d)
			RAMP_RISE: begin
				if (lvl_d != LEVEL_MAX) lvl_d = lvl_d + 6'd1;
				if (lvl_d == LEVEL_MAX) ramp_d = RAMP_FALL;
			end
			RAMP_FALL: begin
				if (lvl_d != LEVEL_MIN) lvl_d = lvl_d - 6'd1;
				if (lvl_d == LEVEL_MIN) ramp_d = RAMP_IDLE;
			end
			default: ;
		endcase

		active_d = (att_d != ATT_REST) || (nack_d != NACK_IDLE) ||
			(ack_d != ACK_IDLE) || (ramp_d != RAMP_IDLE);
	end

	// state update, one per processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LEVEL_MIN;
			att_q   <= ATT_REST;
			nack_q  <= NACK_IDLE;
			ack_q   <= ACK_IDLE;
			ramp_q  <= RAMP_IDLE;
			fc_q    <= 8'd0;
			start_q <= 32'd0;
		end else if (advance) begin
			level_q <= lvl_d;
			att_q   <= att_d;
			nack_q  <= nack_d;
			ack_q   <= ack_d;
			ramp_q  <= ramp_d;
			fc_q    <= fc_d;
			start_q <= start_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_level_q  <= lvl_d;
			out_active_q <= active_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_active_q, out_level_q};

	// a processed item always lands in the result register
	a_advance_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("processed item did not reach the result register");

	// the flash count is cleared whenever attention is idle
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		(att_q == ATT_REST) |-> (fc_q == 8'd0))
		else $error("flash count nonzero while attention idle");

	// a rising ramp turns at the top, a falling ramp ends at zero
	a_ramp_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		((ramp_q == RAMP_RISE) |-> (level_q != LEVEL_MAX)) and
		((ramp_q == RAMP_FALL) |-> (level_q != LEVEL_MIN)))
		else $error("ramp state inconsistent with level");

endmodule

### test/light_signal_sequencer_test.sv
// ----------------------------------------------------------------------------
// light_signal_sequencer_test
// Self-checking bench for the light signal sequencer.
// ----------------------------------------------------------------------------
// Control ticks are pushed into the item stream with random gaps while the
// result side stalls at random. Every accepted tick is run through a local
// model of the level logic and the four signal machines. The result item it
// predicts is queued and then compared field by field with the result items.
// The run steps through several timing settings, from the shortest and the
// zero case to the full 32-bit range. Timestamps are aimed at phase ends so
// that the strict greater-than compare and the wrap are exercised.
// ----------------------------------------------------------------------------
import lss_pkg::*;

// input item, first field in the highest bits
typedef struct packed {
	logic        reset_button;
	logic        dimmer;
	logic        brighter;
	logic        joystick_present;
	logic        manual_enable;
	logic [2:0]  request;
	logic [31:0] now_us;
} tick_t;

// result item
typedef struct packed {
	logic       pad;
	logic       pattern_active;
	logic [5:0] light_level;
} light_t;

class light_scoreboard;
	logic [31:0] on_time_us;
	logic [31:0] off_time_us;
	logic [7:0]  flash_limit;
	logic [5:0]  level;
	att_state_t  att_state;
	nack_state_t nack_state;
	ack_state_t  ack_state;
	ramp_state_t ramp_state;
	logic [7:0]  flash_count;
	logic [31:0] phase_start_us;
	light_t      expected_lights[$];
	int          errors;

	function new();
		on_time_us = ON_TIME_RST;
		off_time_us = OFF_TIME_RST;
		flash_limit = FLASHES_RST;
		level = LEVEL_MIN;
		att_state = ATT_REST;
		nack_state = NACK_IDLE;
		ack_state = ACK_IDLE;
		ramp_state = RAMP_IDLE;
		flash_count = '0;
		phase_start_us = '0;
		errors = 0;
	endfunction

	function void set_register(logic [1:0] index, logic [31:0] value);
		case (index)
			CFG_ON_TIME: on_time_us = value;
			CFG_OFF_TIME: off_time_us = value;
			CFG_FLASHES: flash_limit = value[7:0];
			default: ;
		endcase
	endfunction

	// wrapped time since the shared phase start, strict compare
	function bit phase_over(logic [31:0] now_us, logic [31:0] span_us);
		logic [31:0] elapsed;
		elapsed = now_us - phase_start_us;
		return elapsed > span_us;
	endfunction

	// advance the level and the machines by one accepted tick
	function void note_tick(tick_t t);
		light_t res;
		// manual buttons, brighter wins over dimmer
		if (t.manual_enable) begin
			if (t.brighter) begin
				if (level != LEVEL_MAX) level++;
			end else if (t.dimmer) begin
				if (level != LEVEL_MIN) level--;
			end
		end
		if (t.joystick_present && t.reset_button)
			level = LEVEL_MIN;

		// any request clears the level and restarts the shared timer
		if (t.request != REQ_NONE) begin
			case (t.request)
				REQ_ACK: ack_state = ACK_ON;
				REQ_NACK: nack_state = NACK_ON1;
				REQ_ATTN: begin
					att_state = ATT_ON;
					flash_count = '0;
				end
				REQ_TASK: ramp_state = RAMP_RISE;
				default: ;
			endcase
			level = LEVEL_MIN;
			phase_start_us = t.now_us;
		end

		// attention blink
		case (att_state)
			ATT_ON: begin
				level = LEVEL_MAX;
				if (phase_over(t.now_us, on_time_us)) begin
					att_state = ATT_OFF;
					phase_start_us = t.now_us;
				end
			end
			ATT_OFF: begin
				level = LEVEL_MIN;
				if (phase_over(t.now_us, off_time_us)) begin
					att_state = ATT_ON;
					phase_start_us = t.now_us;
					flash_count++;
					if (flash_count >= flash_limit) begin
						att_state = ATT_REST;
						flash_count = '0;
					end
				end
			end
			default: ;
		endcase

		// nack: on, off, on
		case (nack_state)
			NACK_ON1: begin
				level = LEVEL_MAX;
				if (phase_over(t.now_us, on_time_us)) begin
					nack_state = NACK_OFF;
					phase_start_us = t.now_us;
				end
			end
			NACK_OFF: begin
				level = LEVEL_MIN;
				if (phase_over(t.now_us, off_time_us)) begin
					nack_state = NACK_ON2;
					phase_start_us = t.now_us;
				end
			end
			NACK_ON2: begin
				level = LEVEL_MAX;
				if (phase_over(t.now_us, on_time_us)) begin
					nack_state = NACK_IDLE;
					phase_start_us = t.now_us;
					level = LEVEL_MIN;
				end
			end
			default: ;
		endcase

		// ack: single pulse
		if (ack_state == ACK_ON) begin
			level = LEVEL_MAX;
			if (phase_over(t.now_us, on_time_us)) begin
				ack_state = ACK_IDLE;
				phase_start_us = t.now_us;
				level = LEVEL_MIN;
			end
		end

		// task complete: ramp up to full, then back to dark
		case (ramp_state)
			RAMP_RISE: begin
				if (level != LEVEL_MAX) level++;
				if (level == LEVEL_MAX) ramp_state = RAMP_FALL;
			end
			RAMP_FALL: begin
				if (level != LEVEL_MIN) level--;
				if (level == LEVEL_MIN) ramp_state = RAMP_IDLE;
			end
			default: ;
		endcase

		res.pad = 1'b0;
		res.light_level = level;
		res.pattern_active = att_state != ATT_REST || nack_state != NACK_IDLE ||
			ack_state != ACK_IDLE || ramp_state != RAMP_IDLE;
		expected_lights.push_back(res);
	endfunction

	function void check_light(light_t got);
		light_t want;
		if (expected_lights.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("ERROR: result item %h arrived with no tick pending", got);
			return;
		end
		want = expected_lights.pop_front();
		if (got.light_level !== want.light_level ||
				got.pattern_active !== want.pattern_active || got.pad !== want.pad) begin
			errors++;
			if (errors <= 10)
				$display("ERROR: level exp %0d got %0d, active exp %b got %b, pad exp %b got %b",
					want.light_level, got.light_level, want.pattern_active,
					got.pattern_active, want.pad, got.pad);
		end
	endfunction
endclass

module light_signal_sequencer_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int ROUNDS        = 8;
	localparam int ROUND_TICKS   = 50;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// [31:0] now_us, [34:32] request, [35] manual_enable,
	// [36] joystick_present, [37] brighter, [38] dimmer, [39] reset_button
	logic [39:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [5:0] light_level, [6] pattern_active, [7] zero
	logic [7:0]  m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	light_scoreboard lights;
	bit          steady = 1'b0;
	int          stall_left = 0;
	int          idle_cycles = 0;
	logic [31:0] stamp;

	light_signal_sequencer DUT (.*);

	always #2 clk = ~clk;

	// mostly short gaps, a few long ones, none in steady stretches
	function int pick_gap();
		int r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	// result side stalls
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (!steady && $urandom_range(0, 3) == 0) begin
			stall_left <= pick_gap();
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// result checks and watchdog
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			lights.check_light(m_tdata);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("light_signal_sequencer verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task send_tick(tick_t t);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= t;
		do @(posedge clk); while (!s_tready);
		lights.note_tick(t);
	endtask

	// buttons: {reset_button, dimmer, brighter, joystick_present, manual_enable}
	task push_tick(logic [2:0] req, logic [31:0] step, logic [4:0] buttons);
		stamp = stamp + step;
		send_tick({buttons, req, stamp});
	endtask

	task write_register(logic [1:0] index, logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		lights.set_register(index, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task set_timing(logic [31:0] on_us, logic [31:0] off_us, logic [7:0] flashes);
		write_register(CFG_ON_TIME, on_us);
		write_register(CFG_OFF_TIME, off_us);
		write_register(CFG_FLASHES, {24'd0, flashes});
	endtask

	// wait until every result is in and the pipeline is empty
	task drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (lights.expected_lights.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// random tick, timestamps often aimed right at a phase end
	function tick_t random_tick();
		tick_t t;
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			stamp = stamp + $urandom_range(0, 4);
		else if (r < 75)
			stamp = lights.phase_start_us + lights.on_time_us + $urandom_range(0, 1);
		else if (r < 90)
			stamp = lights.phase_start_us + lights.off_time_us + $urandom_range(0, 1);
		else
			stamp = $urandom;
		t.now_us = stamp;
		r = $urandom_range(0, 99);
		if (r < 3)
			t.request = REQ_TASK + 3'($urandom_range(1, 3));   // codes past task complete
		else if (r < 15)
			t.request = 3'($urandom_range(REQ_ACK, REQ_TASK));
		else
			t.request = REQ_NONE;
		t.manual_enable = 1'($urandom_range(0, 1));
		t.joystick_present = 1'($urandom_range(0, 1));
		t.brighter = ($urandom_range(0, 2) == 0);
		t.dimmer = ($urandom_range(0, 2) == 0);
		t.reset_button = ($urandom_range(0, 9) == 0);
		return t;
	endfunction

	initial begin
		lights = new();
		stamp = 32'hFFFF_FFFC;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: buttons, every request, restarts, the timestamp wrap
		set_timing(32'd3, 32'd2, 8'd2);
		push_tick(REQ_NONE, 0, 5'b00101);
		push_tick(REQ_NONE, 1, 5'b00101);
		push_tick(REQ_NONE, 1, 5'b01101);
		push_tick(REQ_NONE, 1, 5'b01001);
		push_tick(REQ_NONE, 1, 5'b00100);
		push_tick(REQ_NONE, 1, 5'b10000);
		push_tick(REQ_NONE, 1, 5'b10111);
		push_tick(REQ_NONE, 1, 5'b01001);
		push_tick(REQ_ACK, 1, 5'b00000);
		push_tick(REQ_NONE, 3, 5'b00000);
		push_tick(REQ_NONE, 1, 5'b00000);
		push_tick(REQ_NACK, 1, 5'b00000);
		push_tick(REQ_NACK, 2, 5'b00101);
		push_tick(REQ_NONE, 4, 5'b00000);
		push_tick(REQ_NONE, 3, 5'b00000);
		push_tick(REQ_NONE, 4, 5'b00000);
		push_tick(REQ_ATTN, 1, 5'b00000);
		push_tick(REQ_NONE, 4, 5'b00000);
		push_tick(REQ_ACK, 4, 5'b00000);
		push_tick(REQ_NONE, 4, 5'b00000);
		push_tick(REQ_NONE, 4, 5'b00000);
		push_tick(REQ_TASK, 1, 5'b00000);
		push_tick(REQ_NONE, 1, 5'b00101);
		push_tick(REQ_TASK + 3'd1, 1, 5'b00000);
		push_tick(REQ_TASK + 3'd3, 1, 5'b11111);
		drain();

		// random rounds over a spread of timing settings
		for (int round = 0; round < ROUNDS; round++) begin
			case (round)
				0: set_timing(32'd1, 32'd1, 8'd1);
				1: set_timing(32'd0, 32'd0, 8'd0);
				2: set_timing($urandom_range(1, 20), $urandom_range(1, 20),
					8'($urandom_range(1, 8)));
				3: set_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
				4: set_timing($urandom_range(2, 12), $urandom_range(2, 12), 8'hFF);
				// flash count lowered under a running attention pattern
				5: write_register(CFG_FLASHES, 32'd1);
				6: set_timing($urandom, $urandom, 8'($urandom_range(1, 255)));
				default: set_timing(ON_TIME_RST, OFF_TIME_RST, FLASHES_RST);
			endcase
			steady = (round % 3 == 1);
			repeat (ROUND_TICKS) send_tick(random_tick());
			// leave an attention pattern running into the next setting
			push_tick(REQ_ATTN, 1, 5'b00000);
			drain();
		end
		steady = 1'b0;

		if (lights.errors == 0 && lights.expected_lights.size() == 0)
			$display("light_signal_sequencer verification clean");
		else
			$display("light_signal_sequencer verification failed");
		$finish;
	end
endmodule
